// ===== hdl/dmlq_pkg.sv =====
// ----------------------------------------------------------------------------
// dmlq_pkg
// Shared types and constants for the dominance max-level query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmlq_pkg;

  localparam int MAX_POINTS_DEF  = 256;
  localparam int MAX_DIMS_DEF    = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KIND_W        = 2;
  localparam int POINT_IDX_W   = 8;
  localparam int DIM_IDX_W     = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int PCOUNT_W      = 9;
  localparam int DCOUNT_W      = 4;
  localparam int FLOOR_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FLOOR = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_COORD = 2'd0,
    KIND_LOAD_LEVEL = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_EVAL       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } state_t;

  // write strobes and read strobe toward the point store
  typedef struct packed {
    logic coord_we;
    logic level_we;
    logic query_we;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== hdl/dmlq_store.sv =====
// ----------------------------------------------------------------------------
// dmlq_store
// Point store: one coordinate bank per dimension, a level memory and the
// query point. One point is read per cycle while rd_en is high and compared in every active dimension.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmlq_store #(
  parameter int MAX_POINTS  = dmlq_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS    = dmlq_pkg::MAX_DIMS_DEF,
  parameter int VALUE_WIDTH = dmlq_pkg::VALUE_WIDTH_DEF,
  parameter int PW          = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int DW          = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  parameter int NDW         = $clog2(MAX_DIMS + 1)
) (
  input  logic                          clk,
  input  dmlq_pkg::mem_ctl_t            ctl,
  input  logic [PW-1:0]                 wr_point,
  input  logic [DW-1:0]                 wr_dim,
  input  logic signed [VALUE_WIDTH-1:0] wr_value,
  input  logic [PW-1:0]                 rd_addr,
  input  logic [NDW-1:0]                nd,
  output logic signed [VALUE_WIDTH-1:0] rd_level,
  output logic                          rd_dominated
);

  logic signed [VALUE_WIDTH-1:0] level_mem [MAX_POINTS];
  logic signed [VALUE_WIDTH-1:0] query_r   [MAX_DIMS];
  logic signed [VALUE_WIDTH-1:0] coord_q   [MAX_DIMS];
  logic [MAX_DIMS-1:0]           dim_ok;

  always_ff @(posedge clk) begin
    if (ctl.level_we) begin
      level_mem[wr_point] <= wr_value;
    end
    if (ctl.rd_en) begin
      rd_level <= level_mem[rd_addr];
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic signed [VALUE_WIDTH-1:0] bank [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (ctl.coord_we && (wr_dim == DW'(d))) begin
        bank[wr_point] <= wr_value;
      end
      if (ctl.rd_en) begin
        coord_q[d] <= bank[rd_addr];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.query_we && (wr_dim == DW'(d))) begin
        query_r[d] <= wr_value;
      end
    end

    // dimensions at or above the active count always pass
    assign dim_ok[d] = (32'(d) >= 32'(nd)) || (coord_q[d] <= query_r[d]);
  end

  assign rd_dominated = &dim_ok;

endmodule

// ===== hdl/dominance_max_level_query.sv =====
// ----------------------------------------------------------------------------
// dominance_max_level_query
// Evaluate: the scan reads one point per cycle, np being point_count capped at
// MAX_POINTS; ST_SUM then adds the baseline and registers the result.
// in_stall is high until the result is registered, longer while an earlier
// result is held by out_stall; load and query requests do not raise in_stall.
// Reset (synchronous) clears control and sets point_count 0, dim_count 1,
// level_floor 0; the point store and query point hold nothing until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dominance_max_level_query #(
  parameter int MAX_POINTS  = dmlq_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS    = dmlq_pkg::MAX_DIMS_DEF,
  parameter int VALUE_WIDTH = dmlq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dmlq_pkg::KIND_W-1:0]         in_kind,
  input  logic [dmlq_pkg::POINT_IDX_W-1:0]    in_point_index,
  input  logic [dmlq_pkg::DIM_IDX_W-1:0]      in_dim_index,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [VALUE_WIDTH-1:0]       out_level_sum,
  input  logic                                cfg_we,
  input  logic [dmlq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmlq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int NDW  = $clog2(MAX_DIMS + 1);
  localparam int PXW  = (PW > dmlq_pkg::POINT_IDX_W) ? PW : dmlq_pkg::POINT_IDX_W;
  localparam int DXW  = (DW > dmlq_pkg::DIM_IDX_W) ? DW : dmlq_pkg::DIM_IDX_W;
  localparam int CW   = (VALUE_WIDTH > dmlq_pkg::FLOOR_W) ? VALUE_WIDTH
                                                          : dmlq_pkg::FLOOR_W;
  localparam logic signed [CW:0] SAT_HI =
    {{(CW - VALUE_WIDTH + 2){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [CW:0] SAT_LO =
    {{(CW - VALUE_WIDTH + 2){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

  dmlq_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic                          rd_vld_r;
  logic signed [CW-1:0]          best_r, best_nxt;
  logic signed [VALUE_WIDTH-1:0] base_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [dmlq_pkg::PCOUNT_W-1:0] point_count_r;
  logic [dmlq_pkg::DCOUNT_W-1:0] dim_count_r;
  logic signed [dmlq_pkg::FLOOR_W-1:0] level_floor_r;

  dmlq_pkg::kind_t               kind;
  dmlq_pkg::mem_ctl_t            ctl;
  logic                          in_acc;
  logic [PXW-1:0]                pidx_ext;
  logic [DXW-1:0]                didx_ext;
  logic                          p_ok, d_ok;
  logic [CNTW-1:0]               np;
  logic [NDW-1:0]                nd;
  logic signed [VALUE_WIDTH-1:0] rd_level;
  logic                          rd_dominated;
  logic signed [CW-1:0]          lvl_ext;
  logic signed [CW:0]            sum;
  logic signed [CW:0]            sum_sat;

  assign kind     = dmlq_pkg::kind_t'(in_kind);
  assign in_stall = (state_r != dmlq_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pidx_ext = PXW'(in_point_index);
  assign didx_ext = DXW'(in_dim_index);
  assign p_ok     = 32'(in_point_index) < 32'(MAX_POINTS);
  assign d_ok     = 32'(in_dim_index) < 32'(MAX_DIMS);

  assign np = (32'(point_count_r) > 32'(MAX_POINTS)) ? CNTW'(MAX_POINTS)
                                                     : CNTW'(point_count_r);
  assign nd = (32'(dim_count_r) > 32'(MAX_DIMS)) ? NDW'(MAX_DIMS)
                                                 : NDW'(dim_count_r);

  assign ctl.coord_we = in_acc && (kind == dmlq_pkg::KIND_LOAD_COORD) && p_ok && d_ok;
  assign ctl.level_we = in_acc && (kind == dmlq_pkg::KIND_LOAD_LEVEL) && p_ok;
  assign ctl.query_we = in_acc && (kind == dmlq_pkg::KIND_QUERY) && d_ok;
  assign ctl.rd_en    = (state_r == dmlq_pkg::ST_SCAN) && (cnt_r < np);

  dmlq_store #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .PW          (PW),
    .DW          (DW),
    .NDW         (NDW)
  ) u_store (
    .clk          (clk),
    .ctl          (ctl),
    .wr_point     (pidx_ext[PW-1:0]),
    .wr_dim       (didx_ext[DW-1:0]),
    .wr_value     (in_value),
    .rd_addr      (cnt_r[PW-1:0]),
    .nd           (nd),
    .rd_level     (rd_level),
    .rd_dominated (rd_dominated)
  );

  assign lvl_ext = CW'(rd_level);
  assign sum     = (CW + 1)'(best_r) + (CW + 1)'(base_r);

  always_comb begin
    sum_sat = sum;
    if (base_r > 0 && sum > SAT_HI) begin
      sum_sat = SAT_HI;
    end else if (base_r < 0 && sum < SAT_LO) begin
      sum_sat = SAT_LO;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      dmlq_pkg::ST_IDLE: begin
        if (in_acc && kind == dmlq_pkg::KIND_EVAL) begin
          cnt_nxt   = '0;
          best_nxt  = CW'(level_floor_r);
          state_nxt = dmlq_pkg::ST_SCAN;
        end
      end
      dmlq_pkg::ST_SCAN: begin
        if (ctl.rd_en) begin
          cnt_nxt = CNTW'(cnt_r + 1'b1);
        end
        if (rd_vld_r && rd_dominated && (lvl_ext > best_r)) begin
          best_nxt = lvl_ext;
        end
        if (!ctl.rd_en && !rd_vld_r) begin
          state_nxt = dmlq_pkg::ST_SUM;
        end
      end
      dmlq_pkg::ST_SUM: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_sat[VALUE_WIDTH-1:0];
          state_nxt     = dmlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmlq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmlq_pkg::ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= ctl.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc && kind == dmlq_pkg::KIND_EVAL) begin
      base_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      dim_count_r   <= dmlq_pkg::DCOUNT_W'(1);
      level_floor_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmlq_pkg::REG_POINT_COUNT: point_count_r <= cfg_data[dmlq_pkg::PCOUNT_W-1:0];
        dmlq_pkg::REG_DIM_COUNT:   dim_count_r   <= cfg_data[dmlq_pkg::DCOUNT_W-1:0];
        dmlq_pkg::REG_LEVEL_FLOOR: level_floor_r <= cfg_data[dmlq_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level_sum = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmlq_pkg::ST_SCAN |-> cnt_r <= np)
    else $error("scan counter past point count");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == dmlq_pkg::ST_SCAN)
    else $error("read data returned outside scan");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dmlq_pkg::ST_SUM)
    else $error("result raised without a finished scan");

  a_sum_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmlq_pkg::ST_SUM && !out_valid_r |=> out_valid_r)
    else $error("finished scan did not produce a result");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dominance_max_level_query. Loads points, query
// coordinates and evaluate requests in random bursts under random output
// back-pressure. A scoreboard keeps its own copy of the point store and
// registers, predicts every level_sum and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NPTS = dmlq_pkg::MAX_POINTS_DEF;
  localparam int NDIM = dmlq_pkg::MAX_DIMS_DEF;
  localparam logic [dmlq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int Q16 = 65536;

  class level_scoreboard;
    int coord_mem [NPTS*NDIM];
    int level_mem [NPTS];
    int query_pt [NDIM];
    int unsigned point_count;
    int unsigned dim_count;
    int level_floor;
    int sum_queue [$];
    int failures;

    function new();
      point_count = 0;
      dim_count = 1;
      level_floor = 0;
      failures = 0;
    endfunction

    function int active_points();
      return (point_count > NPTS) ? NPTS : point_count;
    endfunction

    function int active_dims();
      return (dim_count > NDIM) ? NDIM : dim_count;
    endfunction

    function int pending();
      return sum_queue.size();
    endfunction

    function void write_reg(logic [dmlq_pkg::CFG_IDX_W-1:0] idx,
                            logic [dmlq_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dmlq_pkg::REG_POINT_COUNT: point_count = data[dmlq_pkg::PCOUNT_W-1:0];
        dmlq_pkg::REG_DIM_COUNT:   dim_count = data[dmlq_pkg::DCOUNT_W-1:0];
        dmlq_pkg::REG_LEVEL_FLOOR: level_floor = data[dmlq_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    endfunction

    // update the store or predict the level sum of an evaluate request
    function void note_request(dmlq_pkg::kind_t kind, logic [7:0] pidx, logic [2:0] didx,
                               int value);
      int np, nd, best, p, d;
      bit hit;
      longint total;
      case (kind)
        dmlq_pkg::KIND_LOAD_COORD: coord_mem[int'(pidx) * NDIM + int'(didx)] = value;
        dmlq_pkg::KIND_LOAD_LEVEL: level_mem[pidx] = value;
        dmlq_pkg::KIND_QUERY:      query_pt[didx] = value;
        dmlq_pkg::KIND_EVAL: begin
          np = active_points();
          nd = active_dims();
          best = level_floor;
          for (p = 0; p < np; p++) begin
            if (level_mem[p] > best) begin
              hit = 1;
              for (d = 0; d < nd; d++)
                if (coord_mem[p * NDIM + d] > query_pt[d]) hit = 0;
              if (hit) best = level_mem[p];
            end
          end
          total = longint'(best) + longint'(value);
          if (total > 64'sd2147483647) total = 64'sd2147483647;
          else if (total < -64'sd2147483648) total = -64'sd2147483648;
          sum_queue = {sum_queue, int'(total)};
        end
        default: ;
      endcase
    endfunction

    function void check_sum(logic signed [31:0] actual);
      int expected;
      if (sum_queue.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected level_sum %h", actual);
      end else begin
        expected = sum_queue.pop_front();
        if (actual !== expected) begin
          failures++;
          if (failures <= 10)
            $display("level_sum mismatch: expected %h actual %h", expected, actual);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [dmlq_pkg::KIND_W-1:0] in_kind;
  logic [dmlq_pkg::POINT_IDX_W-1:0] in_point_index;
  logic [dmlq_pkg::DIM_IDX_W-1:0] in_dim_index;
  logic signed [31:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_level_sum;
  logic cfg_we;
  logic [dmlq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dmlq_pkg::CFG_DATA_W-1:0] cfg_data;

  level_scoreboard sb;
  bit coord_set [NPTS*NDIM];
  bit level_set [NPTS];
  bit query_set [NDIM];
  int burst_left;
  int rx_run;
  int rx_mode;

  dominance_max_level_query dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_point_index(in_point_index),
    .in_dim_index(in_dim_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_level_sum(out_level_sum),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  // receiver back-pressure: runs of no, light, heavy or solid stall
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_run = $urandom_range(1, 60);
    end
    rx_run--;
    case (rx_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 4) == 0);
      2: out_stall = ($urandom_range(0, 9) < 7);
      default: out_stall = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) sb.check_sum(out_level_sum);
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'((int'($urandom_range(0, 32)) - 16) * Q16);
    endcase
  endfunction

  task automatic send_request(dmlq_pkg::kind_t kind, logic [7:0] pidx, logic [2:0] didx,
                              logic [31:0] value);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_point_index = pidx;
    in_dim_index = didx;
    in_value = value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(kind, pidx, didx, value);
    case (kind)
      dmlq_pkg::KIND_LOAD_COORD: coord_set[int'(pidx) * NDIM + int'(didx)] = 1;
      dmlq_pkg::KIND_LOAD_LEVEL: level_set[pidx] = 1;
      dmlq_pkg::KIND_QUERY:      query_set[didx] = 1;
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // hold the sender until every expected result is back and loads are done
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [dmlq_pkg::CFG_IDX_W-1:0] idx,
                           logic [dmlq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // write every entry the next evaluate reads that has never been written
  task automatic fill_window();
    int p, d;
    for (p = 0; p < sb.active_points(); p++) begin
      if (!level_set[p])
        send_request(dmlq_pkg::KIND_LOAD_LEVEL, 8'(p), 3'($urandom), rand_value());
      for (d = 0; d < sb.active_dims(); d++)
        if (!coord_set[p * NDIM + d])
          send_request(dmlq_pkg::KIND_LOAD_COORD, 8'(p), 3'(d), rand_value());
    end
    for (d = 0; d < sb.active_dims(); d++)
      if (!query_set[d])
        send_request(dmlq_pkg::KIND_QUERY, 8'($urandom), 3'(d), rand_value());
  endtask

  task automatic run_phase(int pcount, int dcount, logic [31:0] lfloor, int n);
    int i, r, np, nd;
    logic [7:0] pidx;
    logic [2:0] didx;
    drain();
    write_cfg(dmlq_pkg::REG_POINT_COUNT, ($urandom & 32'hffff_fe00) | 32'(pcount));
    write_cfg(dmlq_pkg::REG_DIM_COUNT, ($urandom & 32'hffff_fff0) | 32'(dcount));
    write_cfg(dmlq_pkg::REG_LEVEL_FLOOR, lfloor);
    write_cfg(REG_UNUSED, $urandom);
    fill_window();
    np = sb.active_points();
    nd = sb.active_dims();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 199) == 0) drain();
      r = $urandom_range(0, 99);
      pidx = (np > 0 && $urandom_range(0, 4) != 0) ? 8'($urandom_range(0, np - 1))
                                                    : 8'($urandom);
      didx = (nd > 0 && $urandom_range(0, 4) != 0) ? 3'($urandom_range(0, nd - 1))
                                                    : 3'($urandom);
      if (r < 35) send_request(dmlq_pkg::KIND_LOAD_COORD, pidx, didx, rand_value());
      else if (r < 55) send_request(dmlq_pkg::KIND_LOAD_LEVEL, pidx, didx, rand_value());
      else if (r < 70) send_request(dmlq_pkg::KIND_QUERY, pidx, didx, rand_value());
      else send_request(dmlq_pkg::KIND_EVAL, pidx, didx, rand_value());
    end
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_point_index = '0;
    in_dim_index = '0;
    in_value = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    rx_run = 0;
    rx_mode = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no points in use: result is floor plus baseline
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_EVAL, 255, 7, 32'h8000_0000);

    drain();
    write_cfg(dmlq_pkg::REG_POINT_COUNT, 2);
    write_cfg(dmlq_pkg::REG_DIM_COUNT, 2);
    write_cfg(dmlq_pkg::REG_LEVEL_FLOOR, 32'h8000_0000);
    write_cfg(REG_UNUSED, 32'hffff_ffff);
    send_request(dmlq_pkg::KIND_LOAD_COORD, 0, 0, 32'(-5 * Q16));
    send_request(dmlq_pkg::KIND_LOAD_COORD, 0, 1, 32'(3 * Q16));
    send_request(dmlq_pkg::KIND_LOAD_COORD, 1, 0, 32'h8000_0000);
    send_request(dmlq_pkg::KIND_LOAD_COORD, 1, 1, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_LOAD_COORD, 255, 7, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 0, 0, 32'(100 * Q16));
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 1, 0, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 255, 7, 32'h8000_0000);
    send_request(dmlq_pkg::KIND_QUERY, 0, 0, 0);
    send_request(dmlq_pkg::KIND_QUERY, 0, 1, 32'(3 * Q16));
    // equal coordinate still dominated; sum saturates high
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 32'h8000_0000);
    send_request(dmlq_pkg::KIND_QUERY, 0, 1, 32'h7fff_ffff);
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 32'hffff_ffff);
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 1);
    // equal levels do not replace the maximum
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 1, 0, 32'(100 * Q16));
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 0);
    // levels at the floor: floor wins, sum saturates low
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 0, 0, 32'h8000_0000);
    send_request(dmlq_pkg::KIND_LOAD_LEVEL, 1, 0, 32'h8000_0000);
    send_request(dmlq_pkg::KIND_EVAL, 0, 0, 32'hffff_ffff);

    run_phase(8, 3, $urandom, 100);
    run_phase(1, 15, 32'h7fff_ffff, 60);
    run_phase(0, 1, 32'h8000_0000, 30);
    run_phase(16, 0, $urandom, 80);
    run_phase(32, 2, 0, 100);
    run_phase(511, 1, 32'h8000_0000, 60);
    run_phase(256, 0, $urandom, 60);
    run_phase(4, 8, 32'(-3 * Q16), 60);

    drain();
    repeat (300) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dmlq_pkg.sv
hdl/dmlq_store.sv
hdl/dominance_max_level_query.sv
test/testbench.sv
